// ===== hdl/bplm_pkg.sv =====
// Shared types, constants and codes of the breakpoint linear mapper.
package bplm_pkg;

  // Breakpoint table geometry.
  localparam int TABLE_SLOTS = 7;
  localparam int MAX_POINTS  = 7;
  localparam int TBL_IDX_W   = 3;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Signed Q8.8 values and the shared add/subtract unit width.
  localparam int VAL_W = 16;
  localparam int ALU_W = VAL_W + 2;
  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_0     = 3'd1;

  typedef struct packed {
    logic signed [VAL_W-1:0] in_value;
    logic                    in_trigger;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic                    out_trigger;
  } out_item_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOW,
    ST_HIGH,
    ST_SEARCH,
    ST_LOAD,
    ST_DX,
    ST_DY,
    ST_ABS,
    ST_T,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  // Read port of the breakpoint table as seen by the sequencer.
  typedef struct packed {
    logic [COUNT_W-1:0]    count;
    logic [CFG_DATA_W-1:0] data;
  } tbl_rd_t;

endpackage

// ===== hdl/bplm_alu.sv =====
// Shared add/subtract unit used for every compare, difference and division step.
module bplm_alu
  import bplm_pkg::*;
(
  input  alu_op_t                 op,
  input  logic signed [ALU_W-1:0] a,
  input  logic signed [ALU_W-1:0] b,
  output logic signed [ALU_W-1:0] y
);

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a - b;
    endcase
  end

endmodule

// ===== hdl/bplm_regs.sv =====
// Configuration registers: breakpoint count and the breakpoint table with one read port.
module bplm_regs
  import bplm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TBL_IDX_W-1:0]  rd_idx,
  output tbl_rd_t               rd
);

  logic [COUNT_W-1:0]    count_r;
  logic [CFG_DATA_W-1:0] tbl_r [TABLE_SLOTS];
  logic [TBL_IDX_W-1:0]  wr_idx;

  assign wr_idx = cfg_index - CFG_POINT_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        tbl_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_POINT_COUNT) begin
        count_r <= cfg_data[COUNT_W-1:0];
      end else if (wr_idx < TBL_IDX_W'(TABLE_SLOTS)) begin
        tbl_r[wr_idx] <= cfg_data;
      end
    end
  end

  always_comb begin
    rd.count = (count_r > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : count_r;
    rd.data  = (rd_idx < TBL_IDX_W'(TABLE_SLOTS)) ? tbl_r[rd_idx] : '0;
  end

endmodule

// ===== hdl/bplm_core.sv =====
// Sequencer and datapath: breakpoint search, differences, multiply and serial division.
module bplm_core
  import bplm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  in_item_t             item,
  input  tbl_rd_t              rd,
  output logic [TBL_IDX_W-1:0] rd_idx,
  input  logic                 out_free,
  output logic                 busy,
  output logic                 done,
  output out_item_t            result
);

  state_t state_r, state_nxt;

  logic [TBL_IDX_W-1:0]    k_r, k_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic                    trig_r, trig_nxt;
  logic [CFG_DATA_W-1:0]   prev_r, prev_nxt;
  logic [VAL_W-1:0]        dx_r, dx_nxt;
  logic signed [VAL_W:0]   dy_r, dy_nxt;
  logic                    neg_r, neg_nxt;
  logic [VAL_W-1:0]        t_r, t_nxt;
  logic [VAL_W-1:0]        rem_r, rem_nxt;
  logic [VAL_W-1:0]        quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;

  alu_op_t                 alu_op;
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic                    alu_neg, alu_le0;

  logic [TBL_IDX_W-1:0]    last_idx;
  logic signed [VAL_W-1:0] rd_x, rd_y, prev_x, prev_y;
  logic [2*VAL_W-1:0]      prod;
  logic [VAL_W:0]          shifted;
  logic [VAL_W:0]          mag_q;

  bplm_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign last_idx = rd.count - TBL_IDX_W'(1);
  assign rd_x     = rd.data[CFG_DATA_W-1:VAL_W];
  assign rd_y     = rd.data[VAL_W-1:0];
  assign prev_x   = prev_r[CFG_DATA_W-1:VAL_W];
  assign prev_y   = prev_r[VAL_W-1:0];
  assign alu_neg  = alu_y[ALU_W-1];
  assign alu_le0  = alu_neg || (alu_y == '0);
  assign prod     = dy_r[VAL_W-1:0] * t_r;
  assign shifted  = {rem_r, quo_r[VAL_W-1]};
  // Floor rounding of a negative quotient bumps the magnitude when a remainder is left.
  assign mag_q    = {1'b0, quo_r} + (VAL_W+1)'(neg_r && (rem_r != '0));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (rd.count == '0) ? ST_DONE : ST_LOW;
        end
      end
      ST_LOW:    state_nxt = alu_le0 ? ST_DONE : ST_HIGH;
      ST_HIGH:   state_nxt = alu_neg ? ST_SEARCH : ST_DONE;
      ST_SEARCH: begin
        if (!((k_r < last_idx) && !alu_neg)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD:   state_nxt = ST_DX;
      ST_DX:     state_nxt = alu_le0 ? ST_DONE : ST_DY;
      ST_DY:     state_nxt = ST_ABS;
      ST_ABS:    state_nxt = ST_T;
      ST_T:      state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: table address, shared unit operands and handshake flags.
  always_comb begin
    rd_idx = '0;
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    busy   = (state_r != ST_IDLE);
    done   = (state_r == ST_DONE) && out_free;
    unique case (state_r)
      ST_IDLE: ;
      ST_LOW: begin
        rd_idx = '0;
        alu_a  = ALU_W'(v_r);
        alu_b  = ALU_W'(rd_x);
      end
      ST_HIGH: begin
        rd_idx = last_idx;
        alu_a  = ALU_W'(v_r);
        alu_b  = ALU_W'(rd_x);
      end
      ST_SEARCH: begin
        rd_idx = k_r;
        alu_a  = ALU_W'(v_r);
        alu_b  = ALU_W'(rd_x);
      end
      ST_LOAD: rd_idx = k_r - TBL_IDX_W'(1);
      ST_DX: begin
        rd_idx = k_r;
        alu_a  = ALU_W'(rd_x);
        alu_b  = ALU_W'(prev_x);
      end
      ST_DY: begin
        rd_idx = k_r;
        alu_a  = ALU_W'(rd_y);
        alu_b  = ALU_W'(prev_y);
      end
      ST_ABS: begin
        alu_a = '0;
        alu_b = ALU_W'(dy_r);
      end
      ST_T: begin
        alu_a = ALU_W'(v_r);
        alu_b = ALU_W'(prev_x);
      end
      ST_MUL: ;
      ST_DIV: begin
        alu_a = ALU_W'($signed({1'b0, shifted}));
        alu_b = ALU_W'($signed({1'b0, dx_r}));
      end
      ST_FIN: begin
        alu_op = neg_r ? ALU_SUB : ALU_ADD;
        alu_a  = ALU_W'(prev_y);
        alu_b  = ALU_W'($signed(mag_q));
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    k_nxt    = k_r;
    v_nxt    = v_r;
    trig_nxt = trig_r;
    prev_nxt = prev_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    neg_nxt  = neg_r;
    t_nxt    = t_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          v_nxt    = item.in_value;
          trig_nxt = item.in_trigger;
          res_nxt  = item.in_value;
        end
      end
      ST_LOW: begin
        res_nxt = rd_y;
      end
      ST_HIGH: begin
        res_nxt = rd_y;
        k_nxt   = TBL_IDX_W'(1);
      end
      ST_SEARCH: begin
        if ((k_r < last_idx) && !alu_neg) begin
          k_nxt = k_r + TBL_IDX_W'(1);
        end
      end
      ST_LOAD: prev_nxt = rd.data;
      ST_DX: begin
        dx_nxt  = alu_y[VAL_W-1:0];
        res_nxt = prev_y;
      end
      ST_DY: begin
        dy_nxt  = alu_y[VAL_W:0];
        neg_nxt = alu_neg;
      end
      ST_ABS: begin
        if (neg_r) begin
          dy_nxt = alu_y[VAL_W:0];
        end
      end
      ST_T: t_nxt = alu_y[VAL_W-1:0];
      ST_MUL: begin
        // The quotient is below 2^16, so the upper half already sits below the divisor.
        rem_nxt = prod[2*VAL_W-1:VAL_W];
        quo_nxt = prod[VAL_W-1:0];
        cnt_nxt = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (!alu_neg) begin
          rem_nxt = alu_y[VAL_W-1:0];
          quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[VAL_W-1:0];
          quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
        end
      end
      ST_FIN: res_nxt = alu_y[VAL_W-1:0];
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    v_r    <= v_nxt;
    trig_r <= trig_nxt;
    prev_r <= prev_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    neg_r  <= neg_nxt;
    t_r    <= t_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign result.out_value   = res_r;
  assign result.out_trigger = trig_r;

endmodule

// ===== hdl/breakpoint_linear_mapper_top.sv =====
// Top level of the breakpoint linear mapper: register file, sequencer and output register.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid/out_stall| out_data (out_item_t)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An empty table passes the value through; a value at or beyond an end point is clamped to
// that point's y; when the enclosing pair has no positive x span the result is the lower
// point's y; otherwise the search, the differences, the multiply and the serial divider, one
// bit a cycle, interpolate it. The next request can be accepted in the first cycle the result
// is offered.
// rst_n is synchronous and clears the sequencer, the output valid and the configuration
// registers.
// in_stall is high while a request is in work; a finished result waits in the output
// register under out_stall, and the next request may be taken meanwhile.
module breakpoint_linear_mapper_top
  import bplm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tbl_rd_t              rd;
  logic [TBL_IDX_W-1:0] rd_idx;
  logic                 busy, done, start, out_free;
  out_item_t            result;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;

  bplm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_idx    (rd_idx),
    .rd        (rd)
  );

  bplm_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (in_data),
    .rd       (rd),
    .rd_idx   (rd_idx),
    .out_free (out_free),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tb_breakpoint_linear_mapper_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the breakpoint linear mapper: directed table, then random phases.
module tb_breakpoint_linear_mapper_top;
  import bplm_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_SETS       = 5;
  localparam int DIR_ROWS       = 24;

  typedef struct packed {
    logic [2:0]       sel;
    logic [VAL_W-1:0] value;
    logic             trig;
    logic             typed;
    logic [VAL_W-1:0] want;
  } dir_row_t;

  // Set 0 is the table as it comes out of reset and is never written.
  localparam int DIRECTED_COUNT [DIR_SETS] = '{0, 7, 1, 4, 2};
  localparam logic [CFG_DATA_W-1:0] DIRECTED_POINTS [DIR_SETS][TABLE_SLOTS] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
    '{32'h8000_7FFF, 32'hC000_8000, 32'hFF00_03E8, 32'h0000_0000,
      32'h0100_FFFF, 32'h03E8_7FFF, 32'h7FFF_8000},
    '{32'h0064_FE0C, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
    // The third x falls below the second one.
    '{32'h0000_0064, 32'h0200_FF38, 32'h0100_012C, 32'h0400_0032, 32'h0, 32'h0, 32'h0},
    '{32'h8000_7FFF, 32'h7FFF_8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}
  };

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{3'd0, 16'h8000, 1'b0, 1'b1, 16'h8000},
    '{3'd0, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF},
    '{3'd0, 16'h0000, 1'b1, 1'b1, 16'h0000},
    '{3'd0, 16'h0001, 1'b0, 1'b0, 16'h0000},
    '{3'd1, 16'h8000, 1'b1, 1'b1, 16'h7FFF},
    '{3'd1, 16'h7FFF, 1'b0, 1'b1, 16'h8000},
    '{3'd1, 16'hB1E0, 1'b1, 1'b0, 16'h0000},
    '{3'd1, 16'hC000, 1'b0, 1'b0, 16'h0000},
    '{3'd1, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{3'd1, 16'h0080, 1'b0, 1'b0, 16'h0000},
    '{3'd1, 16'h03E7, 1'b1, 1'b0, 16'h0000},
    '{3'd1, 16'h7530, 1'b0, 1'b0, 16'h0000},
    '{3'd2, 16'h8000, 1'b0, 1'b1, 16'hFE0C},
    '{3'd2, 16'h0064, 1'b1, 1'b1, 16'hFE0C},
    '{3'd2, 16'h7FFF, 1'b1, 1'b1, 16'hFE0C},
    '{3'd3, 16'h012C, 1'b0, 1'b0, 16'h0000},
    '{3'd3, 16'h0258, 1'b1, 1'b0, 16'h0000},
    '{3'd3, 16'h0100, 1'b0, 1'b0, 16'h0000},
    '{3'd3, 16'hFFFB, 1'b1, 1'b1, 16'h0064},
    '{3'd3, 16'h07D0, 1'b0, 1'b1, 16'h0032},
    '{3'd4, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{3'd4, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{3'd4, 16'h3039, 1'b1, 1'b0, 16'h0000},
    '{3'd4, 16'h8001, 1'b0, 1'b0, 16'h0000}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the configuration, updated as each register write completes.
  logic [COUNT_W-1:0]    tbl_count = '0;
  logic [CFG_DATA_W-1:0] tbl_points [TABLE_SLOTS] = '{default: '0};
  logic [CFG_DATA_W-1:0] next_points [TABLE_SLOTS] = '{default: '0};

  out_item_t mapped_q [$];
  int bad_count = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int idle_cycles = 0;
  int cycle_count = 0;

  breakpoint_linear_mapper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int pt_x(int i);
    return int'($signed(tbl_points[i][31:16]));
  endfunction

  function automatic int pt_y(int i);
    return int'($signed(tbl_points[i][15:0]));
  endfunction

  function automatic out_item_t map_control(in_item_t req);
    int v, n, k, res;
    longint num, den, quo;
    out_item_t result;
    v = int'($signed(req.in_value));
    n = tbl_count;
    if (n > MAX_POINTS) n = MAX_POINTS;
    if (n == 0) begin
      res = v;
    end else if (v <= pt_x(0)) begin
      res = pt_y(0);
    end else if (v >= pt_x(n - 1)) begin
      res = pt_y(n - 1);
    end else begin
      k = 1;
      while (k < n - 1 && pt_x(k) <= v) k++;
      den = pt_x(k) - pt_x(k - 1);
      if (den <= 0) begin
        res = pt_y(k - 1);
      end else begin
        num = longint'(pt_y(k) - pt_y(k - 1)) * longint'(v - pt_x(k - 1));
        quo = num / den;
        // Division truncates toward zero; the mapping rounds toward minus infinity.
        if (num % den != 0 && num < 0) quo--;
        res = pt_y(k - 1) + int'(quo);
      end
    end
    result.out_value = res[VAL_W-1:0];
    result.out_trigger = req.in_trigger;
    return result;
  endfunction

  function automatic int pick_gap();
    int r;
    if ((requests_sent / 150) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Most values land near a breakpoint or inside the table's x span.
  function automatic logic [VAL_W-1:0] pick_value();
    int n, r, v, lo, hi, tmp;
    n = tbl_count;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 15) return VAL_W'($urandom_range(0, 65535));
    if (r < 60) begin
      v = pt_x($urandom_range(0, n - 1)) + $urandom_range(0, 6) - 3;
    end else begin
      lo = pt_x(0);
      hi = pt_x(n - 1);
      if (hi < lo) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      v = lo + $urandom_range(0, hi - lo);
    end
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[VAL_W-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_POINT_COUNT) tbl_count = data[COUNT_W-1:0];
    else tbl_points[idx - CFG_POINT_0] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_table(input int count);
    for (int p = 0; p < TABLE_SLOTS; p++) write_reg(CFG_IDX_W'(CFG_POINT_0 + p), next_points[p]);
    write_reg(CFG_POINT_COUNT, CFG_DATA_W'(count));
  endtask

  task automatic randomize_table();
    int xs [TABLE_SLOTS];
    int n, mode, r, y;
    r = $urandom_range(0, 9);
    if (r == 0) n = 0;
    else if (r == 1) n = 1;
    else if (r == 2) n = 7;
    else n = $urandom_range(2, 7);
    mode = $urandom_range(0, 9);
    for (int i = 0; i < TABLE_SLOTS; i++) xs[i] = $urandom_range(0, 65535) - 32768;
    if (mode == 6) begin
      // Tightly spaced points give short segments and small divisors.
      xs[0] = $urandom_range(0, 60000) - 32768;
      for (int i = 1; i < TABLE_SLOTS; i++) begin
        xs[i] = xs[i - 1] + $urandom_range(1, 400);
        if (xs[i] > 32767) xs[i] = 32767;
      end
    end else if (mode != 8) begin
      xs.sort();
      if (mode == 7) begin
        for (int i = 1; i < TABLE_SLOTS; i++)
          if ($urandom_range(0, 2) == 0) xs[i] = xs[i - 1];
      end
      if (mode == 9 && n > 0) begin
        xs[0] = -32768;
        xs[n - 1] = 32767;
      end
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) y = -32768;
      else if (r == 1) y = 32767;
      else y = $urandom_range(0, 65535);
      next_points[i] = {xs[i][15:0], y[15:0]};
    end
    write_table(n);
  endtask

  task automatic send_request(input in_item_t req, input bit typed, input out_item_t want);
    int gap;
    out_item_t exp_item;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    exp_item = typed ? want : map_control(req);
    mapped_q = {mapped_q, exp_item};
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    in_item_t req;
    out_item_t want;
    int sel, phase_len;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    sel = 0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (int'(DIRECTED[i].sel) != sel) begin
        sel = DIRECTED[i].sel;
        wait_drained();
        next_points = DIRECTED_POINTS[sel];
        write_table(DIRECTED_COUNT[sel]);
      end
      req.in_value = DIRECTED[i].value;
      req.in_trigger = DIRECTED[i].trig;
      want.out_value = DIRECTED[i].want;
      want.out_trigger = DIRECTED[i].trig;
      send_request(req, DIRECTED[i].typed, want);
    end
    want = '0;
    while (requests_sent < DIR_ROWS + RANDOM_ITEMS) begin
      wait_drained();
      randomize_table();
      phase_len = $urandom_range(10, 90);
      repeat (phase_len) begin
        req.in_value = pick_value();
        req.in_trigger = 1'($urandom_range(0, 1));
        send_request(req, 1'b0, want);
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && mapped_q.size() == 0) begin
      $display("breakpoint_linear_mapper_top test passed");
    end else begin
      $display("breakpoint_linear_mapper_top test failed");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and two long holds that back up the block.
  initial begin : receiver
    int stall_left, holds_done, r;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done < 2 && in_valid && results_seen >= (holds_done == 0 ? 200 : 900)) begin
        stall_left = HOLD_CYCLES;
        holds_done++;
      end else if (stall_left == 0 && (cycle_count / 400) % 4 != 1) begin
        r = $urandom_range(0, 99);
        if (r < 8) stall_left = $urandom_range(8, 40);
        else if (r < 35) stall_left = $urandom_range(1, 3);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    cycle_count++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (mapped_q.size() == 0) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS)
            $display("unexpected result: value %0d trigger %0b",
                     $signed(out_data.out_value), out_data.out_trigger);
        end else begin
          want = mapped_q.pop_front();
          if (out_data.out_value !== want.out_value ||
              out_data.out_trigger !== want.out_trigger) begin
            bad_count++;
            if (bad_count <= MAX_REPORTS)
              $display("mismatch: value exp %0d got %0d, trigger exp %0b got %0b",
                       $signed(want.out_value), $signed(out_data.out_value),
                       want.out_trigger, out_data.out_trigger);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("breakpoint_linear_mapper_top test failed");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
hdl/bplm_pkg.sv
hdl/bplm_alu.sv
hdl/bplm_regs.sv
hdl/bplm_core.sv
hdl/breakpoint_linear_mapper_top.sv
tb/tb_breakpoint_linear_mapper_top.sv
